/* rtl/sha256_pkg.sv */
// sha256_pkg: shared types, round constants and sigma functions of the hash engine
// depends on nothing; used by every module under rtl
package sha256_pkg;

    // field widths
    localparam int WORD_W = 32;
    localparam int CNT_W  = 61;
    localparam int LEN_W  = 64;

    // eight 32-bit words, element 0 is word a / h0
    typedef logic [7:0][WORD_W-1:0] sha256_state_t;

    // input item
    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] data_word;
        logic [2:0]        word_index;
        logic [2:0]        valid_bytes;
        logic              last_word;
    } sha256_in_t;

    // result item
    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [2:0]        digest_index;
        logic              digest_last;
    } sha256_out_t;

    // request types
    localparam logic REQ_MSG  = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } sha256_fsm_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic       push;
        logic       load;
        logic       step;
        logic [5:0] rnd;
    } sha256_ctl_t;

    // padding markers, the last round index and the word, digest and byte positions
    localparam logic [WORD_W-1:0] PAD_MARK  = 32'h8000_0000;
    localparam logic [7:0]        PAD_BYTE  = 8'h80;
    localparam logic [5:0]        LAST_RND  = 6'd63;
    localparam logic [3:0]        LAST_WPOS = 4'd15;
    localparam logic [3:0]        LEN_HI_POS = 4'd14;
    localparam logic [2:0]        LAST_DIGEST = 3'd7;
    localparam logic [2:0]        FULL_BYTES = 3'd4;

    // standard initial hash value, h0 in the low word
    localparam sha256_state_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // round constants
    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // compression sigma on word a
    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // compression sigma on word e
    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // schedule sigma on w[t-15]
    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // schedule sigma on w[t-2]
    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

/* rtl/sha256_sched.sv */
// sha256_sched: sixteen-word message window that doubles as the rolling schedule
// depends on sha256_pkg
module sha256_sched (
    input  logic                           clk,
    input  sha256_pkg::sha256_ctl_t        ctl,
    input  logic [sha256_pkg::WORD_W-1:0]  push_word,
    output logic [sha256_pkg::WORD_W-1:0]  w_cur
);

    logic [sha256_pkg::WORD_W-1:0] win_reg [16];
    logic [sha256_pkg::WORD_W-1:0] sched_word;
    logic [sha256_pkg::WORD_W-1:0] in_word;

    // next schedule word from taps of the window
    assign sched_word = win_reg[0] + sha256_pkg::small_sigma0(win_reg[1])
                      + win_reg[9] + sha256_pkg::small_sigma1(win_reg[14]);

    assign in_word = ctl.step ? sched_word : push_word;
    assign w_cur   = win_reg[0];

    // shift line, oldest word at the bottom
    always_ff @(posedge clk)
    begin
        if (ctl.push || ctl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= in_word;
        end
    end

endmodule

/* rtl/sha256_round.sv */
// sha256_round: working variables a..h and the shared one-round compression unit
// depends on sha256_pkg
module sha256_round (
    input  logic                           clk,
    input  sha256_pkg::sha256_ctl_t        ctl,
    input  sha256_pkg::sha256_state_t      chain,
    input  logic [sha256_pkg::WORD_W-1:0]  w_cur,
    output sha256_pkg::sha256_state_t      vars
);

    sha256_pkg::sha256_state_t     vars_reg;
    logic [sha256_pkg::WORD_W-1:0] t1;
    logic [sha256_pkg::WORD_W-1:0] t2;
    logic [sha256_pkg::WORD_W-1:0] ch;
    logic [sha256_pkg::WORD_W-1:0] maj;

    // round function
    assign ch  = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
    assign maj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
               ^ (vars_reg[1] & vars_reg[2]);
    assign t1  = vars_reg[7] + sha256_pkg::big_sigma1(vars_reg[4]) + ch
               + sha256_pkg::ROUND_K[ctl.rnd] + w_cur;
    assign t2  = sha256_pkg::big_sigma0(vars_reg[0]) + maj;

    // load from chaining value or advance one round
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            vars_reg <= chain;
        end
        else if (ctl.step)
        begin
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + t2;
        end
    end

    assign vars = vars_reg;

endmodule

/* rtl/sha256_hash_engine_top.sv */
// sha256_hash_engine_top: sequencer, chaining value, byte count and digest output
// depends on sha256_pkg, sha256_sched, sha256_round
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  in       | in_valid / in_ready    | in_item  (sha256_pkg::sha256_in_t)
//  out      | out_valid / out_ready  | out_item (sha256_pkg::sha256_out_t)
//  cfg      | cfg_we                 | cfg_wdata (length offset in bytes)
//
// an item is taken while in_ready is high; a word that fills a block then holds in_ready
// low through the rounds on the shared round unit and the fold that follows
// padding pushes one word per cycle; a last word then runs its padding blocks before the
// eight digest items, one per cycle while out_ready is high
// in_ready stays low from a last word until the eighth digest item is taken
// rst_n clears control state and restores the standard initial hash value
module sha256_hash_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sha256_pkg::sha256_in_t           in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output sha256_pkg::sha256_out_t          out_item,
    input  logic                             cfg_we,
    input  logic [sha256_pkg::CNT_W-1:0]     cfg_wdata
);

    sha256_pkg::sha256_fsm_t       state_reg, state_next;
    sha256_pkg::sha256_state_t     chain_reg, chain_next;
    logic [sha256_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [sha256_pkg::CNT_W-1:0]  offset_reg;
    logic [3:0]                    wpos_reg, wpos_next;
    logic [5:0]                    rnd_reg, rnd_next;
    logic [2:0]                    idx_reg, idx_next;
    logic                          pad_reg, pad_next;
    logic                          mark_reg, mark_next;
    logic                          skip_reg, skip_next;
    logic                          fin_reg, fin_next;

    sha256_pkg::sha256_ctl_t       ctl;
    logic [sha256_pkg::WORD_W-1:0] push_word;
    logic [sha256_pkg::WORD_W-1:0] w_cur;
    sha256_pkg::sha256_state_t     vars;
    logic [sha256_pkg::CNT_W-1:0]  len_bytes;
    logic [sha256_pkg::LEN_W-1:0]  len_bits;
    logic [2:0]                    nv;
    logic [sha256_pkg::WORD_W-1:0] tail_word;

    // datapath
    sha256_sched u_sched (
        .clk       (clk),
        .ctl       (ctl),
        .push_word (push_word),
        .w_cur     (w_cur)
    );

    sha256_round u_round (
        .clk   (clk),
        .ctl   (ctl),
        .chain (chain_reg),
        .w_cur (w_cur),
        .vars  (vars)
    );

    // length field, wraps modulo 2^64
    assign len_bytes = cnt_reg + offset_reg;
    assign len_bits  = {len_bytes, 3'b000};

    // valid bytes of the last word, capped at four
    assign nv = (in_item.valid_bytes >= sha256_pkg::FULL_BYTES) ?
                sha256_pkg::FULL_BYTES : in_item.valid_bytes;

    // last word, with the padding marker folded in when fewer than four bytes are valid
    always_comb
    begin
        unique case (nv)
            3'd0:    tail_word = {sha256_pkg::PAD_BYTE, 24'h0};
            3'd1:    tail_word = {in_item.data_word[31:24], sha256_pkg::PAD_BYTE, 16'h0};
            3'd2:    tail_word = {in_item.data_word[31:16], sha256_pkg::PAD_BYTE, 8'h0};
            3'd3:    tail_word = {in_item.data_word[31:8], sha256_pkg::PAD_BYTE};
            default: tail_word = in_item.data_word;
        endcase
    end

    // outputs
    assign in_ready  = (state_reg == sha256_pkg::ST_IDLE);
    assign out_valid = (state_reg == sha256_pkg::ST_OUT);
    assign out_item.digest_word  = chain_reg[idx_reg];
    assign out_item.digest_index = idx_reg;
    assign out_item.digest_last  = (idx_reg == sha256_pkg::LAST_DIGEST);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        skip_next  = skip_reg;
        fin_next   = fin_reg;
        push_word  = '0;
        ctl        = '0;
        ctl.rnd    = rnd_reg;

        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.req_type == sha256_pkg::REQ_LOAD)
                    begin
                        chain_next[in_item.word_index] = in_item.data_word;
                    end
                    else if (!in_item.last_word)
                    begin
                        ctl.push  = 1'b1;
                        push_word = in_item.data_word;
                        cnt_next  = cnt_reg + sha256_pkg::CNT_W'(sha256_pkg::FULL_BYTES);
                    end
                    else
                    begin
                        ctl.push  = 1'b1;
                        push_word = tail_word;
                        cnt_next  = cnt_reg + sha256_pkg::CNT_W'(nv);
                        pad_next  = 1'b1;
                        mark_next = (nv == sha256_pkg::FULL_BYTES);
                        skip_next = (nv != sha256_pkg::FULL_BYTES) &&
                                    (wpos_reg == sha256_pkg::LEN_HI_POS);
                        state_next = sha256_pkg::ST_PAD;
                    end
                    if (ctl.push && wpos_reg == sha256_pkg::LAST_WPOS)
                    begin
                        ctl.load   = 1'b1;
                        state_next = sha256_pkg::ST_ROUND;
                    end
                end
            end

            sha256_pkg::ST_PAD:
            begin
                ctl.push = 1'b1;
                if (mark_reg)
                begin
                    push_word = sha256_pkg::PAD_MARK;
                    mark_next = 1'b0;
                    skip_next = (wpos_reg == sha256_pkg::LEN_HI_POS);
                end
                else if (wpos_reg == sha256_pkg::LEN_HI_POS)
                begin
                    push_word = len_bits[63:32];
                end
                else if (wpos_reg == sha256_pkg::LAST_WPOS)
                begin
                    // marker landed in word 14: length goes to the next block
                    skip_next = 1'b0;
                    if (!skip_reg)
                    begin
                        push_word = len_bits[31:0];
                        fin_next  = 1'b1;
                        pad_next  = 1'b0;
                    end
                end
                if (wpos_reg == sha256_pkg::LAST_WPOS)
                begin
                    ctl.load   = 1'b1;
                    state_next = sha256_pkg::ST_ROUND;
                end
            end

            sha256_pkg::ST_ROUND:
            begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == sha256_pkg::LAST_RND)
                begin
                    state_next = sha256_pkg::ST_FOLD;
                end
            end

            sha256_pkg::ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                priority if (fin_reg)
                begin
                    state_next = sha256_pkg::ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end

            sha256_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256_pkg::LAST_DIGEST)
                    begin
                        chain_next = sha256_pkg::INIT_HASH;
                        cnt_next   = '0;
                        fin_next   = 1'b0;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase

        wpos_next = ctl.push ? wpos_reg + 4'd1 : wpos_reg;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256_pkg::ST_IDLE;
            chain_reg  <= sha256_pkg::INIT_HASH;
            cnt_reg    <= '0;
            wpos_reg   <= '0;
            rnd_reg    <= '0;
            idx_reg    <= '0;
            pad_reg    <= 1'b0;
            mark_reg   <= 1'b0;
            skip_reg   <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            chain_reg  <= chain_next;
            cnt_reg    <= cnt_next;
            wpos_reg   <= wpos_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            pad_reg    <= pad_next;
            mark_reg   <= mark_next;
            skip_reg   <= skip_next;
            fin_reg    <= fin_next;
        end
    end

    // length offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            offset_reg <= cfg_wdata;
        end
    end

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while digest is pending");

    a_round_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha256_pkg::ST_ROUND) |-> (wpos_reg == '0))
        else $error("rounds running on a partial block");

    a_digest_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!pad_reg && !mark_reg && wpos_reg == '0))
        else $error("digest shown with padding unfinished");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_item.digest_last) |=> (in_ready && cnt_reg == '0))
        else $error("engine not cleared after last digest item");

    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == sha256_pkg::ST_ROUND) |-> (rnd_reg == '0))
        else $error("round counter not at zero on block start");

endmodule
